FILE: src/tsps_pkg.sv
`default_nettype none

package tsps_pkg;

  // acquisition modes
  typedef enum logic [1:0] {
    MODE_HUNT   = 2'd0,
    MODE_VERIFY = 2'd1,
    MODE_LOCKED = 2'd2,
    MODE_FAILED = 2'd3
  } mode_e;

  // register map, index is paddr[3:2]
  localparam logic [1:0] REG_SYNC_VALUE     = 2'd0;
  localparam logic [1:0] REG_PACKET_LENGTH  = 2'd1;
  localparam logic [1:0] REG_LOCK_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_SEARCH_BUDGET  = 2'd3;

  localparam int unsigned AddrWidth   = 4;
  localparam int unsigned DataWidth   = 32;
  localparam int unsigned PhaseWidth  = 8;
  localparam int unsigned RepWidth    = 6;
  localparam int unsigned BudgetWidth = 20;

  // register reset values
  localparam logic [7:0]             SyncValueRst     = 8'd71;
  localparam logic [PhaseWidth-1:0]  PacketLengthRst  = 8'd188;
  localparam logic [RepWidth-1:0]    LockThresholdRst = 6'd32;
  localparam logic [BudgetWidth-1:0] SearchBudgetRst  = 20'd94000;

  localparam logic [RepWidth-1:0]    RepMax   = {RepWidth{1'b1}};
  localparam logic [BudgetWidth-1:0] BytesMax = {BudgetWidth{1'b1}};

  // packet position after p, wrapping when it would reach the length
  function automatic logic [PhaseWidth-1:0] next_phase(
    input logic [PhaseWidth-1:0] p,
    input logic [PhaseWidth-1:0] len
  );
    logic [PhaseWidth:0] n;
    n = {1'b0, p} + {{PhaseWidth{1'b0}}, 1'b1};
    if (n >= {1'b0, len}) begin
      next_phase = '0;
    end else begin
      next_phase = n[PhaseWidth-1:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: src/ts_packet_sync_acquire.sv
// An accepted request passes the input register, then the result register, to its result.
// Throughput: one byte per cycle while out_stall_i is low; the per-byte update is one compare
// plus counter steps. A stalled result holds while the input register takes one more byte.
// Reset (rst_ni low, asynchronous): mode hunting, phase, repeat and byte counts zero,
// registers at their defaults, both pipeline stages empty.
`default_nettype none

module ts_packet_sync_acquire (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // input channel
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [7:0]                       stream_byte_i,
  input  wire                              restart_i,
  // output channel
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [7:0]                       byte_out_o,
  output logic                             locked_o,
  output logic                             packet_start_o,
  output logic                             sync_failed_o,
  // configuration port
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [tsps_pkg::AddrWidth-1:0]   paddr,
  input  wire  [tsps_pkg::DataWidth-1:0]   pwdata,
  output logic [tsps_pkg::DataWidth-1:0]   prdata,
  output logic                             pready
);

  import tsps_pkg::*;

  // configuration registers
  logic [7:0]             sync_value_q;
  logic [PhaseWidth-1:0]  packet_length_q;
  logic [RepWidth-1:0]    lock_threshold_q;
  logic [BudgetWidth-1:0] search_budget_q;

  // pipeline registers
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_restart_q;
  logic       out_valid_q;

  // acquisition state
  mode_e                  mode_q, mode_d;
  logic [PhaseWidth-1:0]  phase_q, phase_d;
  logic [RepWidth-1:0]    reps_q, reps_d;
  logic [BudgetWidth-1:0] seen_q, seen_d;

  logic                   out_ready;
  logic                   in_ready;
  logic                   advance;
  logic                   cfg_write;
  logic                   is_sync;
  logic                   pkt_start_d;
  logic [RepWidth-1:0]    need;
  mode_e                  mode0;
  logic [PhaseWidth-1:0]  phase0;
  logic [RepWidth-1:0]    reps0;
  logic [BudgetWidth-1:0] seen0;
  logic [PhaseWidth-1:0]  pos;

  // handshake
  assign out_ready   = !out_valid_q || !out_stall_i;
  assign in_ready    = !in_valid_q || out_ready;
  assign advance     = in_valid_q && out_ready;
  assign in_stall_o  = !in_ready;
  assign out_valid_o = out_valid_q;

  // configuration write and read
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_value_q     <= SyncValueRst;
      packet_length_q  <= PacketLengthRst;
      lock_threshold_q <= LockThresholdRst;
      search_budget_q  <= SearchBudgetRst;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_SYNC_VALUE:     sync_value_q     <= pwdata[7:0];
        REG_PACKET_LENGTH:  packet_length_q  <= pwdata[PhaseWidth-1:0];
        REG_LOCK_THRESHOLD: lock_threshold_q <= pwdata[RepWidth-1:0];
        REG_SEARCH_BUDGET:  search_budget_q  <= pwdata[BudgetWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SYNC_VALUE:     prdata = {{(DataWidth-8){1'b0}}, sync_value_q};
      REG_PACKET_LENGTH:  prdata = {{(DataWidth-PhaseWidth){1'b0}}, packet_length_q};
      REG_LOCK_THRESHOLD: prdata = {{(DataWidth-RepWidth){1'b0}}, lock_threshold_q};
      REG_SEARCH_BUDGET:  prdata = {{(DataWidth-BudgetWidth){1'b0}}, search_budget_q};
      default:            prdata = '0;
    endcase
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      in_byte_q    <= stream_byte_i;
      in_restart_q <= restart_i;
    end
  end

  // per-byte acquisition update
  assign is_sync = (in_byte_q == sync_value_q);
  assign need    = (lock_threshold_q == '0) ? {{(RepWidth-1){1'b0}}, 1'b1} : lock_threshold_q;

  always_comb begin
    mode0  = in_restart_q ? MODE_HUNT : mode_q;
    phase0 = in_restart_q ? '0 : phase_q;
    reps0  = in_restart_q ? '0 : reps_q;
    seen0  = in_restart_q ? '0 : seen_q;

    mode_d  = mode0;
    phase_d = phase0;
    reps_d  = reps0;
    seen_d  = seen0;
    pos     = '0;

    case (mode0)
      MODE_LOCKED: begin
        pos     = phase0;
        phase_d = next_phase(phase0, packet_length_q);
      end
      MODE_HUNT, MODE_VERIFY: begin
        if (seen0 != BytesMax) begin
          seen_d = seen0 + {{(BudgetWidth-1){1'b0}}, 1'b1};
        end
        if (mode0 == MODE_HUNT) begin
          if (is_sync) begin
            mode_d  = MODE_VERIFY;
            reps_d  = '0;
            phase_d = next_phase('0, packet_length_q);
          end
        end else begin
          pos = phase0;
          if (phase0 == '0) begin
            if (is_sync) begin
              if (reps0 != RepMax) begin
                reps_d = reps0 + {{(RepWidth-1){1'b0}}, 1'b1};
              end
              if (reps_d >= need) begin
                mode_d = MODE_LOCKED;
              end
              phase_d = next_phase('0, packet_length_q);
            end else begin
              mode_d  = MODE_HUNT;
              reps_d  = '0;
              phase_d = '0;
            end
          end else begin
            phase_d = next_phase(phase0, packet_length_q);
          end
        end
        // budget check after the byte
        if (mode_d != MODE_LOCKED && seen_d >= search_budget_q) begin
          mode_d  = MODE_FAILED;
          reps_d  = '0;
          phase_d = '0;
        end
      end
      default: ;
    endcase

    pkt_start_d = (mode_d == MODE_LOCKED) && (pos == '0);
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_HUNT;
      phase_q <= '0;
      reps_q  <= '0;
      seen_q  <= '0;
    end else if (advance) begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      reps_q  <= reps_d;
      seen_q  <= seen_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_out_o     <= in_byte_q;
      locked_o       <= (mode_d == MODE_LOCKED);
      packet_start_o <= pkt_start_d;
      sync_failed_o  <= (mode_d == MODE_FAILED);
    end
  end

  // checks
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(mode_q) && $stable(phase_q) && $stable(seen_q))
    else $error("acquisition state changed without a request");

  a_failed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_FAILED) && !(advance && in_restart_q) |=> (mode_q == MODE_FAILED))
    else $error("failure cleared without restart");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(locked_o && sync_failed_o) && (!packet_start_o || locked_o))
    else $error("inconsistent result flags");

  a_locked_seen_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !in_restart_q && (mode_q == MODE_LOCKED) |=> $stable(seen_q)
      && (mode_q == MODE_LOCKED))
    else $error("locked mode left or byte count moved without restart");

endmodule

`default_nettype wire

FILE: tb/sv/tb_ts_packet_sync_acquire.sv
`timescale 1ns / 100ps

module tb_ts_packet_sync_acquire;
  import tsps_pkg::*;

  // one stream byte with its restart flag, and the flags expected for it
  typedef struct packed {
    logic [7:0] data;
    logic       restart;
  } ts_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       locked;
    logic       pkt_start;
    logic       failed;
  } sync_flags_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  wire                  in_stall;
  logic [7:0]           stream_byte = 8'h00;
  logic                 restart = 1'b0;
  wire                  out_valid;
  logic                 out_stall = 1'b0;
  wire  [7:0]           byte_out;
  wire                  locked;
  wire                  packet_start;
  wire                  sync_failed;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [DataWidth-1:0] pwdata = '0;
  wire  [DataWidth-1:0] prdata;
  wire                  pready;

  ts_packet_sync_acquire u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .stream_byte_i  (stream_byte),
    .restart_i      (restart),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .byte_out_o     (byte_out),
    .locked_o       (locked),
    .packet_start_o (packet_start),
    .sync_failed_o  (sync_failed),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #10 clk_i = ~clk_i;

  // pending bytes and flags still owed by the block
  ts_byte_t    byte_q[$];
  sync_flags_t flags_q[$];
  int          errors = 0;

  // handshake bookkeeping shared between the edges
  logic byte_taken = 1'b0;
  logic flags_taken = 1'b0;
  logic sender_burst = 1'b0;
  logic recv_burst = 1'b0;
  logic hold_req = 1'b0;
  logic hold_begun = 1'b0;
  int   send_gap = 0;
  int   wait_left = 0;
  int   hold_left = 0;

  // acquisition tracker: settings and state
  logic [7:0]  cfg_sync   = SyncValueRst;
  logic [7:0]  cfg_len    = PacketLengthRst;
  logic [5:0]  cfg_thr    = LockThresholdRst;
  logic [19:0] cfg_budget = SearchBudgetRst;
  mode_e       acq_mode   = MODE_HUNT;
  logic [7:0]  pkt_pos    = 8'd0;
  logic [5:0]  good_reps  = 6'd0;
  logic [19:0] seen_cnt   = 20'd0;

  // next packet position, wrapping when it would reach the length
  function automatic logic [7:0] pos_after(input logic [7:0] p);
    logic [8:0] n;
    n = {1'b0, p} + 9'd1;
    return (n >= {1'b0, cfg_len}) ? 8'd0 : n[7:0];
  endfunction

  // advance the acquisition state by one byte, return its flags
  function automatic sync_flags_t track_sync(input ts_byte_t r);
    logic [7:0]  pos;
    logic [5:0]  need;
    logic        hit;
    sync_flags_t res;
    hit  = (r.data == cfg_sync);
    pos  = 8'd0;
    need = (cfg_thr == 6'd0) ? 6'd1 : cfg_thr;
    if (r.restart) begin
      acq_mode  = MODE_HUNT;
      pkt_pos   = 8'd0;
      good_reps = 6'd0;
      seen_cnt  = 20'd0;
    end
    case (acq_mode)
      MODE_LOCKED: begin
        pos     = pkt_pos;
        pkt_pos = pos_after(pkt_pos);
      end
      MODE_HUNT, MODE_VERIFY: begin
        if (seen_cnt != BytesMax) seen_cnt = seen_cnt + 20'd1;
        if (acq_mode == MODE_HUNT) begin
          if (hit) begin
            acq_mode  = MODE_VERIFY;
            good_reps = 6'd0;
            pkt_pos   = pos_after(8'd0);
          end
        end else begin
          pos = pkt_pos;
          if (pkt_pos == 8'd0) begin
            if (hit) begin
              if (good_reps != RepMax) good_reps = good_reps + 6'd1;
              if (good_reps >= need) acq_mode = MODE_LOCKED;
              pkt_pos = pos_after(8'd0);
            end else begin
              acq_mode  = MODE_HUNT;
              good_reps = 6'd0;
              pkt_pos   = 8'd0;
            end
          end else begin
            pkt_pos = pos_after(pkt_pos);
          end
        end
        // budget runs out without lock
        if (acq_mode != MODE_LOCKED && seen_cnt >= cfg_budget) begin
          acq_mode  = MODE_FAILED;
          good_reps = 6'd0;
          pkt_pos   = 8'd0;
        end
      end
      default: ;
    endcase
    res.data      = r.data;
    res.locked    = (acq_mode == MODE_LOCKED);
    res.pkt_start = (acq_mode == MODE_LOCKED) && (pos == 8'd0);
    res.failed    = (acq_mode == MODE_FAILED);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors = errors + 1;
    end
  endtask

  // request driver, one byte per accepted request
  always @(negedge clk_i) begin : drive_bytes
    logic     nxt_valid;
    ts_byte_t cur;
    nxt_valid = in_valid;
    if (rst_ni) begin
      if (in_valid && byte_taken) begin
        nxt_valid = 1'b0;
        send_gap  = sender_burst ? 0 : $urandom_range(0, 14);
      end
      if (!nxt_valid) begin
        if (send_gap == 0 && byte_q.size() != 0) begin
          cur         = byte_q.pop_front();
          stream_byte <= cur.data;
          restart     <= cur.restart;
          nxt_valid   = 1'b1;
        end else if (send_gap != 0) begin
          send_gap = send_gap - 1;
        end
      end
    end
    in_valid <= nxt_valid;
  end

  // result side stall, with one long hold when asked
  always @(negedge clk_i) begin : drive_stall
    if (rst_ni) begin
      if (hold_req && !hold_begun) begin
        hold_begun = 1'b1;
        hold_left  = 200;
      end
      if (flags_taken) wait_left = recv_burst ? 0 : $urandom_range(0, 14);
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else if (wait_left != 0) begin
        wait_left = wait_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // predict on accepted requests, compare accepted results
  always @(posedge clk_i) begin : watch_ports
    sync_flags_t got;
    sync_flags_t want;
    byte_taken  <= in_valid && !in_stall;
    flags_taken <= out_valid && !out_stall;
    if (rst_ni) begin
      if (in_valid && !in_stall) flags_q.push_back(track_sync({stream_byte, restart}));
      if (out_valid && !out_stall) begin
        got = {byte_out, locked, packet_start, sync_failed};
        if (flags_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual byte %0h", $time, byte_out);
          errors = errors + 1;
        end else begin
          want = flags_q.pop_front();
          check_field("byte_out", want.data, got.data);
          check_field("locked", {7'd0, want.locked}, {7'd0, got.locked});
          check_field("packet_start", {7'd0, want.pkt_start}, {7'd0, got.pkt_start});
          check_field("sync_failed", {7'd0, want.failed}, {7'd0, got.failed});
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] data, input logic rs);
    ts_byte_t r;
    r.data    = data;
    r.restart = rs;
    byte_q.push_back(r);
  endtask

  // apb write, setup then access phase
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SYNC_VALUE:     cfg_sync   = val[7:0];
      REG_PACKET_LENGTH:  cfg_len    = val[7:0];
      REG_LOCK_THRESHOLD: cfg_thr    = val[5:0];
      REG_SEARCH_BUDGET:  cfg_budget = val[19:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] sv, input logic [7:0] len,
                            input logic [5:0] thr, input logic [19:0] budget);
    write_reg(REG_SYNC_VALUE, {24'd0, sv});
    write_reg(REG_PACKET_LENGTH, {24'd0, len});
    write_reg(REG_LOCK_THRESHOLD, {26'd0, thr});
    write_reg(REG_SEARCH_BUDGET, {12'd0, budget});
  endtask

  // packets at the current settings; noisy mixes in bad syncs, junk and restarts
  task automatic queue_stream(input int n, input bit noisy, input bit fresh);
    int left;
    int kind;
    int len;
    int k;
    left = n;
    len  = (cfg_len < 8'd2) ? 1 : int'(cfg_len);
    if (fresh) begin
      push_byte(cfg_sync, 1'b1);
      for (k = 1; k < len && k < n; k++) push_byte(8'($urandom_range(0, 255)), 1'b0);
      left = n - k;
    end
    while (left > 0) begin
      kind = noisy ? $urandom_range(0, 19) : 0;
      if (kind < 14) begin
        // clean packet
        for (k = 0; k < len && left > 0; k++) begin
          push_byte((k == 0) ? cfg_sync : 8'($urandom_range(0, 255)), 1'b0);
          left--;
        end
      end else if (kind < 16) begin
        // packet with a broken sync byte
        for (k = 0; k < len && left > 0; k++) begin
          push_byte((k == 0) ? (cfg_sync ^ 8'($urandom_range(1, 255)))
                             : 8'($urandom_range(0, 255)), 1'b0);
          left--;
        end
      end else if (kind < 19) begin
        // junk run
        for (k = $urandom_range(1, 6); k > 0 && left > 0; k--) begin
          push_byte(8'($urandom_range(0, 255)), 1'b0);
          left--;
        end
      end else begin
        push_byte($urandom_range(0, 1) ? cfg_sync : 8'($urandom_range(0, 255)), 1'b1);
        left--;
      end
    end
  endtask

  task automatic wait_idle;
    while (byte_q.size() != 0 || in_valid || flags_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // default settings: field extremes, sync entry, restart in hunt and verify
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(SyncValueRst, 1'b0);
    push_byte(SyncValueRst, 1'b0);
    push_byte(SyncValueRst, 1'b1);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(SyncValueRst, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b0);
    wait_idle();

    // shortest legal packets, quick lock
    set_config(8'h00, 8'd2, 6'd1, BytesMax);
    queue_stream(20, 1'b1, 1'b1);
    wait_idle();

    // longest packets, both sides without gaps
    set_config(8'hFF, 8'd255, 6'd1, BytesMax);
    sender_burst = 1'b1;
    recv_burst   = 1'b1;
    queue_stream(257, 1'b0, 1'b1);
    wait_idle();
    recv_burst = 1'b0;

    // highest threshold, receiver holds off while the sender keeps going
    set_config(8'($urandom_range(0, 255)), 8'd2, 6'd63, BytesMax);
    hold_req = 1'b1;
    queue_stream(128, 1'b0, 1'b1);
    wait_idle();
    sender_burst = 1'b0;

    // budget of one: fails at once, restart clears and fails again
    set_config(SyncValueRst, 8'd5, 6'd3, 20'd1);
    push_byte(SyncValueRst, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(SyncValueRst, 1'b1);
    push_byte(8'hED, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(SyncValueRst, 1'b0);
    wait_idle();

    // zero threshold, unit length, zero budget
    set_config(8'h3C, 8'd1, 6'd0, 20'd0);
    queue_stream(10, 1'b1, 1'b1);
    wait_idle();

    // zero length, every verify byte must be sync
    set_config(8'hC3, 8'd0, 6'd2, 20'd30);
    queue_stream(16, 1'b1, 1'b1);
    wait_idle();

    // lock at one length, then shrink it under a locked phase
    set_config(8'($urandom_range(0, 255)), 8'd6, 6'd2, BytesMax);
    queue_stream(16, 1'b0, 1'b1);
    wait_idle();
    write_reg(REG_PACKET_LENGTH, 32'd4);
    queue_stream(8, 1'b1, 1'b0);
    wait_idle();

    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ts_packet_sync_acquire] OK");
    end else begin
      $display("[ts_packet_sync_acquire] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("[ts_packet_sync_acquire] ERROR");
    $finish;
  end

endmodule

FILE: ts_packet_sync_acquire.f
src/tsps_pkg.sv
src/ts_packet_sync_acquire.sv
tb/sv/tb_ts_packet_sync_acquire.sv
